/* sv/spm_pkg.sv */
`default_nettype none
package spm_pkg;

  // sample and fixed point formats
  localparam int ADC_BITS  = 12;
  localparam int FRAC_BITS = 8;
  localparam int GAIN_W    = FRAC_BITS + 4;
  localparam int DZ_W      = FRAC_BITS + 1;
  localparam int ANG_W     = 8;

  // pedal datapath widths
  localparam int NUM_W  = ADC_BITS + FRAC_BITS + 3;
  localparam int MAG_W  = NUM_W - 1;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int DIVD_W = PROD_W + 7;
  localparam int PCT_MAX = 100 << FRAC_BITS;
  localparam int QUO_W  = $clog2(PCT_MAX + 1);
  localparam int PCT_W  = 16;

  // servo side
  localparam int PULSE_W     = 14;
  localparam int PULSE_MAX   = (1 << PULSE_W) - 1;
  localparam int NEUTRAL_OFS = 7500 - 2000;
  localparam int NEUTRAL_W   = PULSE_W;
  localparam int RUD_SHIFT   = FRAC_BITS - 3;
  localparam int RUDP_W      = PCT_W + ANG_W + 1;
  localparam int ADJ_MAX     = (PCT_MAX * ((1 << ANG_W) - 1)) >> RUD_SHIFT;
  localparam int BIAS_Q      = ADJ_MAX / 27 + 1;
  localparam int BIAS        = 27 * BIAS_Q;
  localparam int BIAS_W      = $clog2(2 * BIAS + 1);
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP       = (1 << RECIP_SHIFT) / 27 + 1;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int DQ_W        = $clog2(2 * BIAS_Q + 1);

  // pipeline depths
  localparam int PED_LAT   = 5 + QUO_W;
  localparam int PUL_LAT   = 5;
  localparam int TOTAL_LAT = PED_LAT + PUL_LAT;

  // configuration map
  localparam int CFG_AW = 5;
  typedef enum logic [2:0] {
    REG_LEFT_ZERO  = 3'd0,
    REG_LEFT_FULL  = 3'd1,
    REG_RIGHT_ZERO = 3'd2,
    REG_RIGHT_FULL = 3'd3,
    REG_GAIN       = 3'd4,
    REG_DEADZONE   = 3'd5,
    REG_MAX_DEFL   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [DIVD_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    logic [MAG_W-1:0]  den;
  } div_t;

endpackage
`default_nettype wire

/* sv/pedal_to_servo_mapper.sv */
`default_nettype none
// Rudder pedal to servo mapper. Each input transaction carries one sample set
// (left pedal, right pedal, neutral trim ADC readings) and yields exactly one
// output transaction with the servo pulse and the signed rudder percentage in
// Q8.8 (left minus right). Each pedal is mapped from its calibrated zero and
// full points to 0..100 percent, past a deadzone and through a gain, then
// clamped. The block is a 25-stage pipeline: one sample set can enter every
// cycle while the pipeline is not held. Most of the depth is the 15-stage
// restoring divider that forms each pedal's percentage. The whole pipeline
// holds while a result waits at the output. Calibration registers are written
// through the cfg_ port; the user must write them only while no samples are in
// flight, as the block itself does not enforce it.
module pedal_to_servo_mapper (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [39:0]                 in_tdata,   // pot_left, pot_right, pot_trim, pad
  // result channel
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [31:0]                      out_tdata,  // servo_pulse, rudder_percent_q8_8, pad
  // configuration port
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [spm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import spm_pkg::*;

  // ---------------- configuration registers ----------------
  logic [ADC_BITS-1:0] left_zero_r, left_full_r, right_zero_r, right_full_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [DZ_W-1:0]     deadzone_r;
  logic [ANG_W-1:0]    max_defl_r;
  logic                cfg_wr;
  logic [2:0]          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_zero_r  <= '0;
      left_full_r  <= ADC_BITS'(4095);
      right_zero_r <= '0;
      right_full_r <= ADC_BITS'(4095);
      gain_r       <= GAIN_W'(256);
      deadzone_r   <= '0;
      max_defl_r   <= ANG_W'(15);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LEFT_ZERO:  left_zero_r  <= cfg_pwdata[ADC_BITS-1:0];
        REG_LEFT_FULL:  left_full_r  <= cfg_pwdata[ADC_BITS-1:0];
        REG_RIGHT_ZERO: right_zero_r <= cfg_pwdata[ADC_BITS-1:0];
        REG_RIGHT_FULL: right_full_r <= cfg_pwdata[ADC_BITS-1:0];
        REG_GAIN:       gain_r       <= cfg_pwdata[GAIN_W-1:0];
        REG_DEADZONE:   deadzone_r   <= cfg_pwdata[DZ_W-1:0];
        REG_MAX_DEFL:   max_defl_r   <= cfg_pwdata[ANG_W-1:0];
        default: ;  // addresses past the map are ignored
      endcase
    end
  end

  // read back, combinational
  always_comb begin
    case (cfg_idx)
      REG_LEFT_ZERO:  cfg_prdata = 32'(left_zero_r);
      REG_LEFT_FULL:  cfg_prdata = 32'(left_full_r);
      REG_RIGHT_ZERO: cfg_prdata = 32'(right_zero_r);
      REG_RIGHT_FULL: cfg_prdata = 32'(right_full_r);
      REG_GAIN:       cfg_prdata = 32'(gain_r);
      REG_DEADZONE:   cfg_prdata = 32'(deadzone_r);
      REG_MAX_DEFL:   cfg_prdata = 32'(max_defl_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // every stage advances together; the pipe only holds when the output
  // register is full and not being taken
  logic                 en;
  logic                 in_acc;
  logic [TOTAL_LAT-1:0] vld_r;

  assign en        = !vld_r[TOTAL_LAT-1] || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL_LAT-2:0], in_acc};
    end
  end

  // input fields
  logic [ADC_BITS-1:0] pot_left, pot_right, pot_trim;
  assign pot_left  = in_tdata[ADC_BITS-1:0];
  assign pot_right = in_tdata[2*ADC_BITS-1:ADC_BITS];
  assign pot_trim  = in_tdata[3*ADC_BITS-1:2*ADC_BITS];

  // trim rides alongside the pedal pipes
  logic [ADC_BITS-1:0] trim_pipe_r [PED_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      trim_pipe_r[0] <= pot_trim;
      for (int i = 1; i < PED_LAT; i++) begin
        trim_pipe_r[i] <= trim_pipe_r[i-1];
      end
    end
  end

  // ---------------- pedal percentage pipes ----------------
  logic [PCT_W-1:0] pct_left, pct_right;

  spm_pedal u_left (
    .clk      (clk),
    .en       (en),
    .pot      (pot_left),
    .zero_pt  (left_zero_r),
    .full_pt  (left_full_r),
    .gain     (gain_r),
    .deadzone (deadzone_r),
    .pct      (pct_left)
  );

  spm_pedal u_right (
    .clk      (clk),
    .en       (en),
    .pot      (pot_right),
    .zero_pt  (right_zero_r),
    .full_pt  (right_full_r),
    .gain     (gain_r),
    .deadzone (deadzone_r),
    .pct      (pct_right)
  );

  // ---------------- rudder and servo pulse ----------------
  logic [PULSE_W-1:0]      servo_pulse;
  logic signed [PCT_W-1:0] rudder_percent_q8_8;

  spm_pulse u_pulse (
    .clk       (clk),
    .en        (en),
    .pct_left  (pct_left),
    .pct_right (pct_right),
    .trim      (trim_pipe_r[PED_LAT-1]),
    .angle     (max_defl_r),
    .pulse     (servo_pulse),
    .rudder    (rudder_percent_q8_8)
  );

  assign out_tvalid = vld_r[TOTAL_LAT-1];
  assign out_tdata  = {2'b00, rudder_percent_q8_8, servo_pulse};

  // ---------------- assertions ----------------
  // rudder percentage never leaves full left to full right
  a_rudder_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rudder_percent_q8_8 <= PCT_W'(PCT_MAX)) &&
                   (rudder_percent_q8_8 >= -PCT_W'(PCT_MAX)))
    else $error("rudder percentage out of range");

  // pedal percentages are clamped before the difference
  a_pct_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[PED_LAT-1] |-> (pct_left <= PCT_W'(PCT_MAX)) && (pct_right <= PCT_W'(PCT_MAX)))
    else $error("pedal percentage above full travel");

  // a held pipe keeps every in-flight transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("transaction lost or duplicated during stall");

endmodule
`default_nettype wire

/* sv/spm_div_step.sv */
`default_nettype none
module spm_div_step #(
  parameter int SHIFT = 0
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire spm_pkg::div_t div_i,
  output spm_pkg::div_t     div_o
);
  import spm_pkg::*;

  div_t              div_r;
  div_t              div_nxt;
  logic [DIVD_W-1:0] trial;

  // one restoring step: subtract the shifted divisor when it fits
  always_comb begin
    trial   = DIVD_W'(div_i.den) << SHIFT;
    div_nxt = div_i;
    if (div_i.rem >= trial) begin
      div_nxt.rem        = div_i.rem - trial;
      div_nxt.quo[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule
`default_nettype wire

/* sv/spm_pedal.sv */
`default_nettype none
module spm_pedal (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [spm_pkg::ADC_BITS-1:0]    pot,
  input  wire logic [spm_pkg::ADC_BITS-1:0]    zero_pt,
  input  wire logic [spm_pkg::ADC_BITS-1:0]    full_pt,
  input  wire logic [spm_pkg::GAIN_W-1:0]      gain,
  input  wire logic [spm_pkg::DZ_W-1:0]        deadzone,
  output logic      [spm_pkg::PCT_W-1:0]       pct
);
  import spm_pkg::*;

  typedef enum logic [1:0] {
    CLS_NORM,
    CLS_ZERO,
    CLS_FULL
  } cls_t;

  // stage 1: offsets from the calibrated points
  logic signed [NUM_W-1:0] z_s, f_s, v_s, d_s, base, num, den;
  cls_t                    cls_nxt;
  logic [MAG_W-1:0]        num_abs, den_abs;

  always_comb begin
    z_s  = NUM_W'($signed({1'b0, zero_pt}));
    f_s  = NUM_W'($signed({1'b0, full_pt}));
    v_s  = NUM_W'($signed({1'b0, pot}));
    d_s  = NUM_W'($signed({1'b0, deadzone}));
    base = (zero_pt == full_pt) ? '0 : (z_s <<< FRAC_BITS) + (f_s - z_s) * d_s;
    num  = (v_s <<< FRAC_BITS) - base;
    den  = (f_s <<< FRAC_BITS) - base;
    if (num == '0 || gain == '0) begin
      cls_nxt = CLS_ZERO;
    end else if (den == '0) begin
      cls_nxt = num[NUM_W-1] ? CLS_ZERO : CLS_FULL;
    end else if (num[NUM_W-1] != den[NUM_W-1]) begin
      cls_nxt = CLS_ZERO;
    end else begin
      cls_nxt = CLS_NORM;
    end
    num_abs = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    den_abs = den[NUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
  end

  cls_t              cls1_r, cls2_r, cls3_r, cls4_r;
  logic [MAG_W-1:0]  num1_r, den1_r, den2_r, den3_r;
  logic [PROD_W-1:0] prod2_r;
  logic [DIVD_W-1:0] nv3_r;
  logic              ovf4_r;
  div_t              div4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cls1_r  <= cls_nxt;
      num1_r  <= num_abs;
      den1_r  <= den_abs;
      // stage 2: gain
      cls2_r  <= cls1_r;
      prod2_r <= PROD_W'(num1_r) * PROD_W'(gain);
      den2_r  <= den1_r;
      // stage 3: scale to percent
      cls3_r  <= cls2_r;
      nv3_r   <= DIVD_W'(prod2_r) * DIVD_W'(100);
      den3_r  <= den2_r;
      // stage 4: flag a quotient that would not fit, for saturation, and load the divider
      cls4_r      <= cls3_r;
      ovf4_r      <= (nv3_r >> QUO_W) >= DIVD_W'(den3_r);
      div4_r.rem  <= nv3_r;
      div4_r.quo  <= '0;
      div4_r.den  <= den3_r;
    end
  end

  // restoring divider, one quotient bit per stage
  div_t div_w [QUO_W+1];
  cls_t cls_pipe_r [QUO_W];
  logic ovf_pipe_r [QUO_W];

  assign div_w[0] = div4_r;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    spm_div_step #(.SHIFT(QUO_W - 1 - k)) u_step (
      .clk   (clk),
      .en    (en),
      .div_i (div_w[k]),
      .div_o (div_w[k+1])
    );
  end

  // class and overflow flags ride along with the divider stages
  always_ff @(posedge clk) begin
    if (en) begin
      cls_pipe_r[0] <= cls4_r;
      ovf_pipe_r[0] <= ovf4_r;
      for (int k = 1; k < QUO_W; k++) begin
        cls_pipe_r[k] <= cls_pipe_r[k-1];
        ovf_pipe_r[k] <= ovf_pipe_r[k-1];
      end
    end
  end

  // final stage: clamp and special cases
  logic [PCT_W-1:0] pct_r, pct_nxt;

  always_comb begin
    case (cls_pipe_r[QUO_W-1])
      CLS_ZERO: pct_nxt = '0;
      CLS_FULL: pct_nxt = PCT_W'(PCT_MAX);
      CLS_NORM: begin
        if (ovf_pipe_r[QUO_W-1] || div_w[QUO_W].quo > QUO_W'(PCT_MAX)) begin
          pct_nxt = PCT_W'(PCT_MAX);
        end else begin
          pct_nxt = PCT_W'(div_w[QUO_W].quo);
        end
      end
      default: pct_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pct_r <= pct_nxt;
    end
  end

  assign pct = pct_r;

endmodule
`default_nettype wire

/* sv/spm_pulse.sv */
`default_nettype none
module spm_pulse (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic        [spm_pkg::PCT_W-1:0]    pct_left,
  input  wire logic        [spm_pkg::PCT_W-1:0]    pct_right,
  input  wire logic        [spm_pkg::ADC_BITS-1:0] trim,
  input  wire logic        [spm_pkg::ANG_W-1:0]    angle,
  output logic             [spm_pkg::PULSE_W-1:0]  pulse,
  output logic signed      [spm_pkg::PCT_W-1:0]    rudder
);
  import spm_pkg::*;

  logic signed [PCT_W-1:0]  rud1_r, rud2_r, rud3_r, rud4_r, rud5_r;
  logic [NEUTRAL_W-1:0]     neu1_r, neu2_r, neu3_r, neu4_r;
  logic signed [RUDP_W-1:0] ra2_r, adj;
  logic [BIAS_W-1:0]        b3_r;
  logic [RUDP_W-1:0]        b_sum;
  logic [BIAS_W+RECIP_W-1:0] bm;
  logic [DQ_W-1:0]          q4_r;
  logic signed [PULSE_W+2:0] p_s;
  logic [PULSE_W-1:0]       pulse5_r, pulse_nxt;

  always_comb begin
    adj   = ra2_r >>> RUD_SHIFT;
    // bias keeps the dividend positive so the reciprocal floors correctly
    b_sum = RUDP_W'(adj) + RUDP_W'(BIAS);
    bm    = (BIAS_W + RECIP_W)'(b3_r) * (BIAS_W + RECIP_W)'(RECIP);
    p_s   = (PULSE_W + 3)'($signed({1'b0, neu4_r})) + (PULSE_W + 3)'($signed({1'b0, q4_r}))
          - (PULSE_W + 3)'(BIAS_Q);
    if (p_s < 0) begin
      pulse_nxt = '0;
    end else if (p_s > (PULSE_W + 3)'(PULSE_MAX)) begin
      pulse_nxt = PULSE_W'(PULSE_MAX);
    end else begin
      pulse_nxt = p_s[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rud1_r   <= $signed(pct_left) - $signed(pct_right);
      neu1_r   <= NEUTRAL_W'(trim) + NEUTRAL_W'(NEUTRAL_OFS);
      rud2_r   <= rud1_r;
      neu2_r   <= neu1_r;
      ra2_r    <= RUDP_W'(rud1_r) * RUDP_W'($signed({1'b0, angle}));
      rud3_r   <= rud2_r;
      neu3_r   <= neu2_r;
      b3_r     <= b_sum[BIAS_W-1:0];
      rud4_r   <= rud3_r;
      neu4_r   <= neu3_r;
      q4_r     <= bm[RECIP_SHIFT +: DQ_W];
      rud5_r   <= rud4_r;
      pulse5_r <= pulse_nxt;
    end
  end

  assign pulse  = pulse5_r;
  assign rudder = rud5_r;

endmodule
`default_nettype wire

/* verif/spm_checker.sv */
`default_nettype none
module spm_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output int               err_count,
  output int               pending,
  output int               result_count
);
  import spm_pkg::*;

  typedef struct {
    logic [13:0] pulse;
    logic [15:0] rudder;
  } servo_cmd_t;

  servo_cmd_t cmd_q[$];
  longint lz, lf, rz, rf, gain, dz, angle;

  function automatic longint pedal_pct(longint v, longint z, longint f);
    longint base, num, den, p;
    base = (z == f) ? 0 : z * 256 + (f - z) * dz;
    num = v * 256 - base;
    den = f * 256 - base;
    if (num == 0 || gain == 0) return 0;
    if (den == 0) return (num > 0) ? 25600 : 0;
    if ((num > 0) != (den > 0)) return 0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    p = (100 * num * gain) / den;
    return (p > 25600) ? 25600 : p;
  endfunction

  function automatic servo_cmd_t servo_from_samples(logic [39:0] d);
    servo_cmd_t c;
    longint rud, n, q, dd;
    rud = pedal_pct(d[11:0], lz, lf) - pedal_pct(d[23:12], rz, rf);
    dd = 27 * 256;
    n = (5500 + longint'(d[35:24])) * dd + rud * angle * 8;
    q = n / dd;
    if (n % dd != 0 && n < 0) q--;
    if (q < 0) q = 0;
    if (q > 16383) q = 16383;
    c.pulse = q[13:0];
    c.rudder = rud[15:0];
    return c;
  endfunction

  task automatic report(string what);
    $display("mismatch: %s", what);
    err_count++;
  endtask

  always @(posedge clk) begin
    servo_cmd_t e;
    if (!rst_n) begin
      lz = 0; lf = 4095; rz = 0; rf = 4095; gain = 256; dz = 0; angle = 15;
      cmd_q.delete();
    end else begin
      // register write on the access cycle
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_idx_t'(cfg_paddr[4:2]))
          REG_LEFT_ZERO:  lz = cfg_pwdata[11:0];
          REG_LEFT_FULL:  lf = cfg_pwdata[11:0];
          REG_RIGHT_ZERO: rz = cfg_pwdata[11:0];
          REG_RIGHT_FULL: rf = cfg_pwdata[11:0];
          REG_GAIN:       gain = cfg_pwdata[11:0];
          REG_DEADZONE:   dz = cfg_pwdata[8:0];
          REG_MAX_DEFL:   angle = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) cmd_q.push_back(servo_from_samples(in_tdata));
      if (out_tvalid && out_tready) begin
        result_count++;
        if (cmd_q.size() == 0) report("result transaction with nothing expected");
        else begin
          e = cmd_q.pop_front();
          if (out_tdata[13:0] !== e.pulse)
            report($sformatf("servo_pulse got %0d want %0d", out_tdata[13:0], e.pulse));
          if (out_tdata[29:14] !== e.rudder)
            report($sformatf("rudder got %0d want %0d", $signed(out_tdata[29:14]),
                             $signed(e.rudder)));
        end
      end
    end
    pending = cmd_q.size();
  end

  initial begin
    err_count = 0;
    pending = 0;
    result_count = 0;
  end
endmodule
`default_nettype wire

/* verif/tb.sv */
`default_nettype none
module tb;
  import spm_pkg::*;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [39:0] in_tdata;     // pot_left, pot_right, pot_trim, pad
  logic        out_tvalid, out_tready;
  logic [31:0] out_tdata;    // servo_pulse, rudder_percent_q8_8, pad
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          err_count, pending, result_count;
  int          send_idle, recv_idle;   // percent of cycles each side idles
  int          sent;

  pedal_to_servo_mapper dut (.*);

  spm_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // out_tready stalls at random, the percentage set by the current phase
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  // one register write: setup cycle, access cycle, then the bus is left idle
  task automatic reg_write(cfg_idx_t idx, int val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  // drive one sample set, with random idle cycles ahead of it
  task automatic send_samples(logic [11:0] l, logic [11:0] r, logic [11:0] t);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {4'b0, t, r, l};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // wait for the pipe to empty out completely before touching calibration
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TOTAL_LAT + 4) @(posedge clk);
  endtask

  task automatic set_calibration(int lz, int lf, int rz, int rf, int g, int d, int a);
    reg_write(REG_LEFT_ZERO, lz);
    reg_write(REG_LEFT_FULL, lf);
    reg_write(REG_RIGHT_ZERO, rz);
    reg_write(REG_RIGHT_FULL, rf);
    reg_write(REG_GAIN, g);
    reg_write(REG_DEADZONE, d);
    reg_write(REG_MAX_DEFL, a);
  endtask

  // half the sample values near either end of the ADC range, half anywhere
  function automatic logic [11:0] pick_adc();
    case ($urandom_range(3))
      0: return 12'($urandom_range(4095));
      1: return 12'($urandom_range(300));
      2: return 12'(4095 - $urandom_range(300));
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_samples(pick_adc(), pick_adc(), 12'($urandom));
  endtask

  task automatic random_calibration();
    int z, f;
    z = $urandom_range(4095);
    f = ($urandom_range(9) == 0) ? z : $urandom_range(4095);
    reg_write(REG_LEFT_ZERO, z);
    reg_write(REG_LEFT_FULL, f);
    reg_write(REG_RIGHT_ZERO, $urandom_range(4095));
    reg_write(REG_RIGHT_FULL, $urandom_range(4095));
    reg_write(REG_GAIN, ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                 : $urandom_range(200, 400));
    reg_write(REG_DEADZONE, $urandom_range(256));
    reg_write(REG_MAX_DEFL, ($urandom_range(4) == 0) ? $urandom_range(255)
                                                     : $urandom_range(135));
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0; in_tdata = 0; out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    send_idle = 34; recv_idle = 48; sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset calibration, extremes of every sample field
    send_samples(0, 0, 0);
    send_samples(4095, 0, 4095);
    send_samples(0, 4095, 0);
    send_samples(4095, 4095, 2048);
    send_samples(12'hAAA, 12'h555, 12'hAAA);
    send_samples(12'h555, 12'hAAA, 12'h555);
    // pause until every expected result is back
    drain();
    // reversed ranges with deadzone, high gain, widest angle
    set_calibration(4095, 0, 3000, 1000, 4095, 64, 255);
    send_samples(4095, 3000, 0);
    send_samples(0, 1000, 4095);
    send_samples(2000, 2000, 100);
    send_samples(3000, 0, 4095);
    drain();
    // equal zero and full, zero gain, full deadzone
    set_calibration(1000, 1000, 0, 0, 0, 256, 0);
    send_samples(1500, 10, 0);
    send_samples(500, 0, 4095);
    drain();
    set_calibration(1000, 1000, 0, 0, 256, 256, 135);
    send_samples(1500, 10, 0);
    send_samples(500, 0, 4095);
    send_samples(1000, 4095, 2000);
    drain();
    // deadzone over the whole span, clamps both ways
    set_calibration(100, 4000, 100, 4000, 4095, 256, 135);
    send_samples(4095, 0, 0);
    send_samples(0, 4095, 4095);
    send_samples(4000, 4000, 1000);
    drain();

    // random phases: both sides idling at two mixes of rates, then neither idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 34 : (ph == 1) ? 48 : 0;
      recv_idle = (ph == 0) ? 48 : (ph == 1) ? 34 : 0;
      for (int k = 0; k < 4; k++) begin
        random_calibration();
        random_burst(100);
        drain();
      end
    end
    set_calibration(0, 4095, 0, 4095, 256, 0, 15);
    random_burst(50);
    drain();

    $display("sent %0d sample sets, %0d results checked, over 18 calibration settings",
             sent, result_count);
    $display("covering reversed and flat ranges, deadzone, gain and angle extremes");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
